// ===== sv/gqce_pkg.sv =====
package gqce_pkg;

	typedef enum logic [10:0] {
		PH_FLAGS  = 11'b00000000001,
		PH_CID    = 11'b00000000010,
		PH_Q      = 11'b00000000100,
		PH_DIGITS = 11'b00000001000,
		PH_HDR    = 11'b00000010000,
		PH_FTYPE  = 11'b00000100000,
		PH_FSKIP  = 11'b00001000000,
		PH_FLEN   = 11'b00010000000,
		PH_TAGHDR = 11'b00100000000,
		PH_ENTRY  = 11'b01000000000,
		PH_REST   = 11'b10000000000
	} phase_t;

	localparam logic [1:0] KIND_SNI    = 2'd0;
	localparam logic [1:0] KIND_UAID   = 2'd1;
	localparam logic [1:0] KIND_VER    = 2'd2;
	localparam logic [1:0] KIND_STATUS = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_RESET     = 3'd1;
	localparam logic [2:0] ST_VERSION   = 3'd2;
	localparam logic [2:0] ST_HDR_LONG  = 3'd3;
	localparam logic [2:0] ST_NON_STRM  = 3'd4;
	localparam logic [2:0] ST_NOT_CHLO  = 3'd5;
	localparam logic [2:0] ST_TRUNC     = 3'd6;

	localparam logic [31:0] TAG_CHLO = 32'h43484C4F;
	localparam logic [31:0] TAG_SNI  = 32'h534E4900;
	localparam logic [31:0] TAG_UAID = 32'h55414944;
	localparam logic [31:0] TAG_VER  = 32'h56455200;

	localparam logic REG_MIN_VER   = 1'b0;
	localparam logic REG_NONCE_VER = 1'b1;

	typedef struct packed {
		logic [1:0]  kind;
		logic [19:0] base;
		logic [31:0] vstart;
		logic [31:0] vend;
		logic        bad;
		logic [2:0]  status;
		logic        seen;
		logic        last;
	} result_t;

	localparam int RESULT_W = $bits(result_t);

endpackage

// ===== sv/gquic_chlo_tag_extractor.sv =====
// A result is computed combinationally from its accepted byte and registered in the result queue.
// Throughput: one payload byte per cycle while the result queue has room; a byte may cause
// a tag and a status result, so the two-entry headroom of the result queue sets ready.
// Reset: arst_n clears parse state and queue; registers return to 24 and 33.
// No clearing pass.
module gquic_chlo_tag_extractor #(
	parameter int MAX_PACKET_BYTES = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // payload_byte
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // value_base[19:0], value_start, value_end, bad_range,
	                               // end_status[2:0], chlo_seen, zero fill
	output logic [1:0]  m_tuser,   // result_kind
	output logic        m_tlast,   // last_result
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [9:0]  cfg_data
);
	logic [9:0] min_ver_q, nonce_ver_q;
	logic       acc;
	logic       push0, push1, room;
	gqce_pkg::result_t r0, r1, q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_ver_q   <= 10'd24;
			nonce_ver_q <= 10'd33;
		end else if (cfg_we) begin
			case (cfg_index)
				gqce_pkg::REG_MIN_VER:   min_ver_q   <= cfg_data;
				gqce_pkg::REG_NONCE_VER: nonce_ver_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_tready = room;
	assign acc = s_tvalid && s_tready;

	gqce_parser #(.MAX_PACKET_BYTES(MAX_PACKET_BYTES)) u_parser (
		.clk, .arst_n, .en(acc), .b(s_tdata), .last(s_tlast),
		.min_version(min_ver_q), .nonce_min_version(nonce_ver_q),
		.push0, .r0, .push1, .r1
	);

	gqce_out_buf u_buf (
		.clk, .arst_n, .push0, .d0(r0), .push1, .d1(r1),
		.room, .valid(m_tvalid), .q, .pop(m_tready)
	);

	assign m_tuser = q.kind;
	assign m_tlast = q.last;
	assign m_tdata = {7'd0, q.seen, q.status, q.bad, q.vend, q.vstart, q.base};
endmodule

// ===== sv/gqce_out_buf.sv =====
// Four-entry result queue; ready when at least two slots are free.
module gqce_out_buf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push0,
	input  gqce_pkg::result_t     d0,
	input  logic                  push1,
	input  gqce_pkg::result_t     d1,
	output logic                  room,
	output logic                  valid,
	output gqce_pkg::result_t     q,
	input  logic                  pop
);
	gqce_pkg::result_t mem_q [4];
	logic [1:0] rd_q;
	logic [1:0] wr_q;
	logic [2:0] cnt_q;
	logic [1:0] n_push;
	logic       do_pop;

	assign do_pop = pop && valid;
	assign n_push = {1'b0, push0} + {1'b0, push1};
	assign valid  = cnt_q != 3'd0;
	assign q      = mem_q[rd_q];
	assign room   = (cnt_q - {2'b0, do_pop}) <= 3'd2;

	always_ff @(posedge clk) begin
		if (push0) begin
			mem_q[wr_q] <= d0;
			if (push1) mem_q[wr_q + 2'd1] <= d1;
		end else if (push1) begin
			mem_q[wr_q] <= d1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + n_push;
			rd_q  <= rd_q + {1'b0, do_pop};
			cnt_q <= cnt_q + {1'b0, n_push} - {2'b0, do_pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4) else $error("result queue overflow");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 3'd0) |-> !valid) else $error("empty queue shows valid");
	a_push1_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(push0 || push1) |-> room) else $error("push without room");
endmodule

// ===== sv/gqce_parser.sv =====
// Per-byte parse step: state update plus up to two results.
module gqce_parser #(
	parameter int MAX_PACKET_BYTES = 2048
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [7:0]        b,
	input  logic              last,
	input  logic [9:0]        min_version,
	input  logic [9:0]        nonce_min_version,
	output logic              push0,
	output gqce_pkg::result_t r0,
	output logic              push1,
	output gqce_pkg::result_t r1
);
	localparam logic [15:0] MAXP = 16'(MAX_PACKET_BYTES);

	gqce_pkg::phase_t ph_q, ph_d;
	logic [15:0] pos_q;
	logic [7:0]  pflags_q, pflags_d;
	logic signed [15:0] ver_q, ver_d;
	logic [7:0]  skip_q, skip_d;
	logic [16:0] fleft_q, fleft_d;
	logic        ftpe_q, ftpe_d;
	logic [15:0] fstart_q, fstart_d;
	logic [31:0] acc_q, acc_d;
	logic [15:0] tags_q, tags_d;
	logic [31:0] prior_q, prior_d;
	logic [31:0] tag_q, tag_d;
	logic        chlo_q, chlo_d;
	logic        done_q, done_d;
	logic [2:0]  code_q, code_d;
	logic [19:0] area_q, area_d;

	logic        emit;
	logic [1:0]  ekind;
	logic [31:0] tagn;
	logic [7:0]  hs;
	logic [2:0]  st;
	logic [2:0]  lenb;
	logic        trunc_f;
	logic signed [15:0] vnext;

	always_comb begin
		ph_d = ph_q; pflags_d = pflags_q; ver_d = ver_q; skip_d = skip_q;
		fleft_d = fleft_q; ftpe_d = ftpe_q; fstart_d = fstart_q; acc_d = acc_q;
		tags_d = tags_q; prior_d = prior_q; tag_d = tag_q; chlo_d = chlo_q;
		done_d = done_q; code_d = code_q; area_d = area_q;
		emit = 1'b0; ekind = gqce_pkg::KIND_SNI; tagn = '0; hs = '0; lenb = '0;
		trunc_f = 1'b0; st = gqce_pkg::ST_OK;
		vnext = (ver_q * 16'sd10) + $signed({8'd0, b}) - 16'sd48;
		if (!done_q) begin
			if (pos_q >= MAXP) begin
				done_d = 1'b1; code_d = gqce_pkg::ST_TRUNC;
			end else begin
				case (ph_q)
					gqce_pkg::PH_FLAGS: begin
						pflags_d = b;
						if (b[1]) begin
							done_d = 1'b1; code_d = gqce_pkg::ST_RESET;
						end else if (!b[0]) begin
							done_d = 1'b1; code_d = gqce_pkg::ST_VERSION;
						end else if (b[3]) begin
							ph_d = gqce_pkg::PH_CID; skip_d = 8'd8;
						end else ph_d = gqce_pkg::PH_Q;
					end
					gqce_pkg::PH_CID: begin
						skip_d = skip_q - 8'd1;
						if (skip_d == 8'd0) ph_d = gqce_pkg::PH_Q;
					end
					gqce_pkg::PH_Q: begin
						if (b != 8'h51) begin
							done_d = 1'b1; code_d = gqce_pkg::ST_VERSION;
						end else begin
							ph_d = gqce_pkg::PH_DIGITS; skip_d = '0; ver_d = '0;
						end
					end
					gqce_pkg::PH_DIGITS: begin
						ver_d = vnext;
						skip_d = skip_q + 8'd1;
						if (skip_d == 8'd3) begin
							if (vnext < $signed({6'd0, min_version})) begin
								done_d = 1'b1; code_d = gqce_pkg::ST_VERSION;
							end else begin
								hs = 8'd13;
								if (pflags_q[2] && vnext >= $signed({6'd0, nonce_min_version}))
									hs = hs + 8'd32;
								hs = hs + ((pflags_q[5:4] != 2'd0) ?
									{5'd0, pflags_q[5:4], 1'b0} : 8'd1);
								skip_d = hs;
								ph_d = gqce_pkg::PH_HDR;
							end
						end
					end
					gqce_pkg::PH_HDR: begin
						skip_d = skip_q - 8'd1;
						if (skip_d == 8'd0) ph_d = gqce_pkg::PH_FTYPE;
					end
					gqce_pkg::PH_FTYPE: begin
						if (!b[7]) begin
							done_d = 1'b1; code_d = gqce_pkg::ST_NON_STRM;
						end else begin
							lenb = (b[4:2] != 3'd0) ? (b[4:2] + 3'd1) : 3'd0;
							skip_d = {6'd0, b[1:0]} + 8'd1 + {4'd0, 1'b0, lenb};
							if (b[4:2] == 3'd7) skip_d = {6'd0, b[1:0]} + 8'd9;
							ftpe_d = !b[5];
							ph_d = gqce_pkg::PH_FSKIP;
						end
					end
					gqce_pkg::PH_FSKIP: begin
						skip_d = skip_q - 8'd1;
						if (skip_d == 8'd0) begin
							if (ftpe_q) begin
								ph_d = gqce_pkg::PH_TAGHDR; skip_d = '0; tag_d = '0;
								acc_d = '0; fstart_d = pos_q + 16'd1;
							end else begin
								ph_d = gqce_pkg::PH_FLEN; acc_d = '0;
							end
						end
					end
					gqce_pkg::PH_FLEN: begin
						if (skip_q[0]) acc_d = {16'd0, b, acc_q[7:0]};
						else acc_d = {24'd0, b};
						skip_d = skip_q + 8'd1;
						if (skip_d == 8'd2) begin
							fleft_d = {1'b0, acc_d[15:0]};
							ph_d = gqce_pkg::PH_TAGHDR; skip_d = '0; tag_d = '0;
							acc_d = '0; fstart_d = pos_q + 16'd1;
							if (fleft_d == 17'd0) begin
								done_d = 1'b1; code_d = gqce_pkg::ST_TRUNC;
							end
						end
					end
					default: begin
						tagn = {tag_q[23:0], b};
						if (ph_q == gqce_pkg::PH_TAGHDR) begin
							if (skip_q < 8'd4) tag_d = tagn;
							else if (skip_q == 8'd4) acc_d = {acc_q[31:8], b};
							else if (skip_q == 8'd5) acc_d = {acc_q[31:16], b, acc_q[7:0]};
							skip_d = skip_q + 8'd1;
							if (skip_q == 8'd3) begin
								if (tagn == gqce_pkg::TAG_CHLO) chlo_d = 1'b1;
								else begin
									done_d = 1'b1; code_d = gqce_pkg::ST_NOT_CHLO;
									skip_d = skip_q;
								end
							end
							if (skip_q == 8'd7) begin
								tags_d = acc_q[15:0];
								area_d = {4'd0, fstart_q} + {1'b0, acc_q[15:0], 3'd0} + 20'd8;
								prior_d = '0; skip_d = '0;
								ph_d = (acc_q[15:0] != 16'd0) ?
									gqce_pkg::PH_ENTRY : gqce_pkg::PH_REST;
							end
						end else if (ph_q == gqce_pkg::PH_ENTRY) begin
							if (skip_q == 8'd0) tag_d = {24'd0, b};
							else if (skip_q < 8'd4) tag_d = tagn;
							else case (skip_q[1:0])
								2'd0: acc_d = {acc_q[31:8], b};
								2'd1: acc_d = {acc_q[31:16], b, acc_q[7:0]};
								2'd2: acc_d = {acc_q[31:24], b, acc_q[15:0]};
								default: acc_d = {b, acc_q[23:0]};
							endcase
							if (skip_q == 8'd0) acc_d = '0;
							skip_d = skip_q + 8'd1;
							if (skip_q == 8'd7) begin
								if (tag_q == gqce_pkg::TAG_SNI) begin
									emit = 1'b1; ekind = gqce_pkg::KIND_SNI;
								end else if (tag_q == gqce_pkg::TAG_UAID) begin
									emit = 1'b1; ekind = gqce_pkg::KIND_UAID;
								end else if (tag_q == gqce_pkg::TAG_VER) begin
									emit = 1'b1; ekind = gqce_pkg::KIND_VER;
								end
								prior_d = acc_d;
								tags_d = tags_q - 16'd1;
								skip_d = '0;
								if (tags_d == 16'd0) ph_d = gqce_pkg::PH_REST;
							end
						end
						if (!done_d && !ftpe_q) begin
							fleft_d = fleft_q - 17'd1;
							if (fleft_d == 17'd0) begin
								if (ph_d == gqce_pkg::PH_TAGHDR) trunc_f = skip_d < 8'd4;
								else if (ph_d == gqce_pkg::PH_ENTRY)
									trunc_f = skip_d >= 8'd1 && skip_d <= 8'd3;
								if (trunc_f) begin
									done_d = 1'b1; code_d = gqce_pkg::ST_TRUNC;
								end else ph_d = gqce_pkg::PH_FTYPE;
							end
						end
					end
				endcase
			end
		end
		// end status from the updated state
		if (done_d) st = code_d;
		else begin
			case (ph_d)
				gqce_pkg::PH_FLAGS, gqce_pkg::PH_CID, gqce_pkg::PH_Q,
				gqce_pkg::PH_DIGITS, gqce_pkg::PH_HDR: st = gqce_pkg::ST_HDR_LONG;
				gqce_pkg::PH_FTYPE: st = gqce_pkg::ST_OK;
				gqce_pkg::PH_FSKIP, gqce_pkg::PH_FLEN: st = gqce_pkg::ST_TRUNC;
				gqce_pkg::PH_TAGHDR: st = (!ftpe_d || skip_d < 8'd4) ?
					gqce_pkg::ST_TRUNC : gqce_pkg::ST_OK;
				gqce_pkg::PH_ENTRY: st = (!ftpe_d || (skip_d >= 8'd1 && skip_d <= 8'd3)) ?
					gqce_pkg::ST_TRUNC : gqce_pkg::ST_OK;
				default: st = ftpe_d ? gqce_pkg::ST_OK : gqce_pkg::ST_TRUNC;
			endcase
		end
	end

	logic r_tag;
	assign r_tag = en && emit;
	always_comb begin
		r0 = '0; r1 = '0;
		r0.kind = ekind; r0.base = area_q; r0.vstart = prior_q; r0.vend = acc_d;
		r0.bad = acc_d < prior_q; r0.seen = 1'b1;
		r1.kind = gqce_pkg::KIND_STATUS; r1.status = st; r1.seen = chlo_d; r1.last = 1'b1;
		push0 = r_tag; push1 = en && last;
		if (!r_tag) r0 = r1;
		if (!r_tag) begin
			push0 = en && last; push1 = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= gqce_pkg::PH_FLAGS; pos_q <= '0; pflags_q <= '0; ver_q <= '1;
			skip_q <= '0; fleft_q <= '0; ftpe_q <= 1'b0; fstart_q <= '0; acc_q <= '0;
			tags_q <= '0; prior_q <= '0; tag_q <= '0; chlo_q <= 1'b0; done_q <= 1'b0;
			code_q <= '0; area_q <= '0;
		end else if (en) begin
			if (last) begin
				ph_q <= gqce_pkg::PH_FLAGS; pos_q <= '0; pflags_q <= '0; ver_q <= '1;
				skip_q <= '0; fleft_q <= '0; ftpe_q <= 1'b0; fstart_q <= '0;
				acc_q <= '0; tags_q <= '0; prior_q <= '0; tag_q <= '0; chlo_q <= 1'b0;
				done_q <= 1'b0; code_q <= '0; area_q <= '0;
			end else begin
				ph_q <= ph_d; pflags_q <= pflags_d; ver_q <= ver_d; skip_q <= skip_d;
				fleft_q <= fleft_d; ftpe_q <= ftpe_d; fstart_q <= fstart_d; acc_q <= acc_d;
				tags_q <= tags_d; prior_q <= prior_d; tag_q <= tag_d; chlo_q <= chlo_d;
				done_q <= done_d; code_q <= code_d; area_q <= area_d;
				if (pos_q != 16'hFFFF) pos_q <= pos_q + 16'd1;
			end
		end
	end

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		($past(done_q) && !$past(en && last) && done_q == 1'b0) |-> !$past(arst_n))
		else $error("end status lost before last byte");
	a_tag_needs_chlo: assert property (@(posedge clk) disable iff (!arst_n)
		r_tag |-> chlo_q) else $error("tag result without CHLO");
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(ph_q)) else $error("phase not one-hot");
endmodule
